>>> design/sprite_indexed_run_decoder_top_assert.svh
// Assertion macros used by the checker file.
`ifndef SPRITE_INDEXED_RUN_DECODER_TOP_ASSERT_SVH
`define SPRITE_INDEXED_RUN_DECODER_TOP_ASSERT_SVH

// Checked only outside reset.
`define SIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SIRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/sird_pkg.sv
package sird_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 15;
  localparam int unsigned ROW_W      = 14;
  localparam int unsigned ADDR_W     = 30;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ARG_W      = 14;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_PIXEL     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MISPLACED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TRUNC     = 2'd3;

  localparam logic [OP_W-1:0] OP_COL = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN = 2'd1;
  localparam logic [OP_W-1:0] OP_ROW = 2'd2;
  localparam logic [OP_W-1:0] OP_END = 2'd3;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_HIGH = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] color;
    logic              last;
  } result_t;

endpackage

>>> design/sprite_indexed_run_decoder_top.sv
// Channel | Dir | Beat                                                   | Accept
// in_     | in  | tdata[7:0] data byte, tlast stream end                 | tvalid & tready
// out_    | out | tdata col/row/addr/index, tuser kind, tlast last result | tvalid & tready
// cfg_    | in  | APB write/read, sprite_width @0x0, sprite_height @0x4  | psel & penable
// One byte per cycle while the result queue has room; a byte passes the input register, then the queue.
// A byte yields up to two results: the 4-entry result queue drains one per cycle while out_tready is high,
// so decoding stalls only while fewer than two entries are free.
// The row*width multiply and address add sit in the single decode stage.
// rst_n is synchronous; it clears decode state, queue pointers and both registers.
// in_tready does not depend on out_tready.
module sprite_indexed_run_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sird_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // stream_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [14:0] column, [28:15] row, [58:29] pixel_address, [66:59] color_index, zero pad
  output logic [sird_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [sird_pkg::OUT_USER_W-1:0]    out_tuser,  // [1:0] kind
  output logic                               out_tlast,  // last_result
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sird_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sird_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [sird_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [sird_pkg::DIM_W-1:0] width_r;
  logic [sird_pkg::DIM_W-1:0] height_r;

  logic                        s1_valid_r;
  logic [sird_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_end_r;
  logic                        s1_fire;
  logic                        in_fire;

  sird_pkg::phase_t            ph_r, ph_nxt;
  logic [sird_pkg::BYTE_W-1:0] word_low_r, word_low_nxt;
  logic [sird_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [sird_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [sird_pkg::ARG_W-1:0]  run_r, run_nxt;
  logic                        halted_r, halted_nxt;

  logic [2*sird_pkg::BYTE_W-1:0] word;
  logic [sird_pkg::OP_W-1:0]     op;
  logic [sird_pkg::ARG_W-1:0]    arg;
  logic [sird_pkg::ADDR_W-1:0]   prod;
  logic [sird_pkg::ADDR_W:0]     addr_sum;
  logic [sird_pkg::ARG_W-1:0]    run_dec;
  logic                          dim_zero;

  sird_pkg::result_t res_a, res_b, end_res;
  logic [1:0]        push_n;

  sird_pkg::result_t                  fifo_r [sird_pkg::FIFO_DEPTH];
  logic [sird_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [sird_pkg::FIFO_CNT_W-1:0]    cnt_r;
  logic                               pop;
  sird_pkg::result_t                  head;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == sird_pkg::REG_HEIGHT)
                      ? sird_pkg::CFG_DATA_W'(height_r)
                      : sird_pkg::CFG_DATA_W'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == sird_pkg::REG_HEIGHT) begin
        height_r <= cfg_pwdata[sird_pkg::DIM_W-1:0];
      end else begin
        width_r <= cfg_pwdata[sird_pkg::DIM_W-1:0];
      end
    end
  end

  // input register
  assign s1_fire   = s1_valid_r && (cnt_r <= sird_pkg::FIFO_CNT_W'(sird_pkg::FIFO_DEPTH - 2));
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  // decode
  assign word     = {s1_byte_r, word_low_r};
  assign op       = word[sird_pkg::OP_W-1:0];
  assign arg      = word[2*sird_pkg::BYTE_W-1:sird_pkg::OP_W];
  assign prod     = sird_pkg::ADDR_W'(row_r * width_r);
  assign addr_sum = {1'b0, prod} + (sird_pkg::ADDR_W + 1)'(col_r);
  assign run_dec  = run_r - 1'b1;
  assign dim_zero = (width_r == '0) || (height_r == '0);

  always_comb begin
    ph_nxt       = ph_r;
    word_low_nxt = word_low_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    run_nxt      = run_r;
    halted_nxt   = halted_r;
    res_a        = '0;
    res_b        = '0;
    end_res      = '0;
    push_n       = 2'd0;
    if (s1_fire) begin
      if (dim_zero) begin
        if (s1_end_r) begin
          res_a.kind = sird_pkg::KIND_DONE;
          res_a.last = 1'b1;
          push_n     = 2'd1;
        end
      end else if (!halted_r) begin
        unique case (ph_r)
          sird_pkg::PH_RUN: begin
            res_a.kind   = sird_pkg::KIND_PIXEL;
            res_a.column = col_r;
            res_a.row    = row_r;
            res_a.addr   = addr_sum[sird_pkg::ADDR_W-1:0];
            res_a.color  = s1_byte_r;
            res_a.last   = 1'b1;
            push_n       = 2'd1;
            col_nxt      = col_r + 1'b1;
            run_nxt      = run_dec;
            if (run_dec == '0) begin
              col_nxt = '0;
              ph_nxt  = sird_pkg::PH_LOW;
            end
          end
          sird_pkg::PH_HIGH: begin
            ph_nxt = sird_pkg::PH_LOW;
            case (op)
              sird_pkg::OP_COL: col_nxt = sird_pkg::COL_W'(arg);
              sird_pkg::OP_ROW: row_nxt = arg;
              sird_pkg::OP_RUN: begin
                if (arg == '0) begin
                  col_nxt = '0;
                end else begin
                  run_nxt = arg;
                  ph_nxt  = sird_pkg::PH_RUN;
                end
              end
              default: begin
                if (!s1_end_r) begin
                  res_a.kind = sird_pkg::KIND_MISPLACED;
                  res_a.last = 1'b1;
                  push_n     = 2'd1;
                  halted_nxt = 1'b1;
                end
              end
            endcase
          end
          sird_pkg::PH_LOW: begin
            word_low_nxt = s1_byte_r;
            ph_nxt       = sird_pkg::PH_HIGH;
          end
          default: ph_nxt = sird_pkg::PH_LOW;
        endcase
        if (s1_end_r) begin
          end_res.kind = (ph_nxt == sird_pkg::PH_LOW) ? sird_pkg::KIND_DONE
                                                       : sird_pkg::KIND_TRUNC;
          end_res.last = 1'b1;
          if (push_n == 2'd0) begin
            res_a  = end_res;
            push_n = 2'd1;
          end else begin
            res_a.last = 1'b0;
            res_b      = end_res;
            push_n     = 2'd2;
          end
        end
      end
      if (s1_end_r) begin
        ph_nxt       = sird_pkg::PH_LOW;
        word_low_nxt = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        run_nxt      = '0;
        halted_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= sird_pkg::PH_LOW;
      word_low_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      run_r      <= '0;
      halted_r   <= 1'b0;
    end else begin
      ph_r       <= ph_nxt;
      word_low_r <= word_low_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      run_r      <= run_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // result queue
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = sird_pkg::OUT_DATA_W'({head.color, head.addr, head.row, head.column});
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + 1'b1] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + sird_pkg::FIFO_PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + sird_pkg::FIFO_PTR_W'(pop);
      cnt_r    <= cnt_r + sird_pkg::FIFO_CNT_W'(push_n) - sird_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

>>> design/sird_checker.sv
`include "sprite_indexed_run_decoder_top_assert.svh"

module sird_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sird_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sird_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  `SIRD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result beat changed")
  `SIRD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result beat right after reset")
  `SIRD_ASSERT(a_status_last, out_tvalid && out_tuser != sird_pkg::KIND_PIXEL |-> out_tlast, "status beat without last")
  `SIRD_ASSERT(a_status_zero, out_tvalid && out_tuser != sird_pkg::KIND_PIXEL |-> out_tdata == '0, "status beat with pixel data")

endmodule

bind sprite_indexed_run_decoder_top sird_checker u_sird_checker (.*);

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sird_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int ROW_LSB      = COL_W;
  localparam int ADDR_LSB     = COL_W + ROW_W;
  localparam int IDX_LSB      = ADDR_LSB + ADDR_W;
  localparam int PAD_LSB      = IDX_LSB + BYTE_W;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              fin;
    chk_t              chk;
    logic [KIND_W-1:0] kind;
  } stim_t;

  typedef struct packed {
    logic              cfg;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [BYTE_W-1:0] b;
    logic              fin;
    chk_t              chk;
    logic [KIND_W-1:0] kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  sprite_indexed_run_decoder_top DUT (.*);

  always #10 clk = ~clk;

  // decoder shadow state
  logic [DIM_W-1:0]  cfg_w = '0;
  logic [DIM_W-1:0]  cfg_h = '0;
  phase_t            ph = PH_LOW;
  logic [BYTE_W-1:0] wlow = '0;
  logic [COL_W-1:0]  ccol = '0;
  logic [ROW_W-1:0]  crow = '0;
  logic [ARG_W-1:0]  rleft = '0;
  logic              halt = 1'b0;
  result_t           step_res [2];
  int                n_res;

  stim_t   stim_q[$];
  result_t pixel_q[$];
  stim_t   cur_beat;
  result_t exp_r;
  result_t fix_r;
  bit      beat_taken = 0;
  bit      quiet = 0;
  int      sender_gap = 0;
  int      rx_gap = 0;
  int      hold_req = 0;
  int      hold_done = 0;
  int      hold_left = 0;
  int      errors = 0;
  int      cycles = 0;
  int      pushed = 0;

  dir_row_t dir_tab [27] = '{
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFF, 1'b1, CHK_ONE,   KIND_DONE},
    '{1'b1, 16'hFFFF,  16'hFFFF,  8'h00, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFE, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFF, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFC, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFF, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h09, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hFF, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h01, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h03, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b1, CHK_ONE,   KIND_DONE},
    '{1'b0, 16'd0,     16'd0,     8'h03, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_ONE,   KIND_MISPLACED},
    '{1'b0, 16'd0,     16'd0,     8'h55, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'hAA, 1'b1, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b1, CHK_ONE,   KIND_TRUNC},
    '{1'b1, 16'd3,     16'd1,     8'h00, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h0D, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h00, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h11, 1'b0, CHK_MODEL, KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h22, 1'b1, CHK_MODEL, KIND_PIXEL},
    '{1'b1, 16'd5,     16'd0,     8'h00, 1'b0, CHK_NONE,  KIND_PIXEL},
    '{1'b0, 16'd0,     16'd0,     8'h33, 1'b1, CHK_ONE,   KIND_DONE}
  };

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_t make_beat(logic [BYTE_W-1:0] b, logic fin, chk_t chk,
                                      logic [KIND_W-1:0] kind);
    stim_t s;
    s.b = b;
    s.fin = fin;
    s.chk = chk;
    s.kind = kind;
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      $error("%s: expected %0d, got %0d", name, e, g);
      errors++;
    end
  endfunction

  function automatic void clear_sprite();
    ph = PH_LOW;
    wlow = '0;
    ccol = '0;
    crow = '0;
    rleft = '0;
    halt = 1'b0;
  endfunction

  function automatic void emit(logic [KIND_W-1:0] k, logic [COL_W-1:0] c,
                               logic [ROW_W-1:0] rw, logic [ADDR_W-1:0] a,
                               logic [BYTE_W-1:0] ix);
    step_res[n_res] = '{k, c, rw, a, ix, 1'b0};
    n_res++;
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic fin);
    logic [15:0] w;
    logic [ARG_W-1:0] arg;
    longint unsigned prod;
    n_res = 0;
    if (cfg_w == 0 || cfg_h == 0) begin
      if (fin) begin
        emit(KIND_DONE, '0, '0, '0, '0);
        clear_sprite();
      end
    end else if (halt) begin
      if (fin) clear_sprite();
    end else begin
      case (ph)
        PH_RUN: begin
          prod = 64'(crow) * 64'(cfg_w) + 64'(ccol);
          emit(KIND_PIXEL, ccol, crow, prod[ADDR_W-1:0], b);
          ccol = ccol + 1'b1;
          rleft = rleft - 1'b1;
          if (rleft == 0) begin
            ccol = '0;
            ph = PH_LOW;
          end
        end
        PH_HIGH: begin
          w = {b, wlow};
          arg = w[15:OP_W];
          ph = PH_LOW;
          case (w[OP_W-1:0])
            OP_COL: ccol = COL_W'(arg);
            OP_ROW: crow = arg;
            OP_RUN: begin
              if (arg == 0) ccol = '0;
              else begin
                rleft = arg;
                ph = PH_RUN;
              end
            end
            default: begin
              if (!fin) begin
                emit(KIND_MISPLACED, '0, '0, '0, '0);
                halt = 1'b1;
              end
            end
          endcase
        end
        default: begin
          wlow = b;
          ph = PH_HIGH;
        end
      endcase
      if (fin) begin
        emit((ph == PH_LOW) ? KIND_DONE : KIND_TRUNC, '0, '0, '0, '0);
        clear_sprite();
      end
    end
    if (n_res > 0) step_res[n_res-1].last = 1'b1;
  endfunction

  // result check, then prediction for the input beat taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result beat: kind %0d, tdata %0h", out_tuser, out_tdata);
        errors++;
      end else begin
        exp_r = pixel_q.pop_front();
        check_field("kind", exp_r.kind, out_tuser);
        check_field("column", exp_r.column, out_tdata[0 +: COL_W]);
        check_field("row", exp_r.row, out_tdata[ROW_LSB +: ROW_W]);
        check_field("pixel_address", exp_r.addr, out_tdata[ADDR_LSB +: ADDR_W]);
        check_field("color_index", exp_r.color, out_tdata[IDX_LSB +: BYTE_W]);
        check_field("tdata_pad", 0, out_tdata[OUT_DATA_W-1:PAD_LSB]);
        check_field("last_result", exp_r.last, out_tlast);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, in_tlast);
      case (cur_beat.chk)
        CHK_MODEL: for (int i = 0; i < n_res; i++) pixel_q.push_back(step_res[i]);
        CHK_ONE: begin
          fix_r = '0;
          fix_r.kind = cur_beat.kind;
          fix_r.last = 1'b1;
          pixel_q.push_back(fix_r);
        end
        default: ;
      endcase
      beat_taken = 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == RUN_LIMIT) begin
      $display("sprite_indexed_run_decoder_top regression: fail");
      $finish;
    end
  end

  // byte sender
  always @(negedge clk) begin
    if (!rst_n) in_tvalid <= 1'b0;
    else if (!in_tvalid || beat_taken) begin
      beat_taken = 0;
      if (sender_gap > 0) begin
        sender_gap--;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur_beat = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= cur_beat.b;
        in_tlast <= cur_beat.fin;
        sender_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  task automatic drain();
    while (stim_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] a,
                            input logic [CFG_DATA_W-1:0] wd,
                            output logic [CFG_DATA_W-1:0] rd);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= a;
    cfg_pwdata <= wd;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    logic [CFG_ADDR_W-1:0] a;
    logic [CFG_DATA_W-1:0] val;
    logic [CFG_DATA_W-1:0] rd;
    for (int i = 0; i < 2; i++) begin
      a = (i == 0) ? {REG_WIDTH, 2'b00} : {REG_HEIGHT, 2'b00};
      val = (i == 0) ? CFG_DATA_W'(w) : CFG_DATA_W'(h);
      apb_access(1'b1, a, val, rd);
      apb_access(1'b0, a, '0, rd);
      check_field((i == 0) ? "sprite_width" : "sprite_height", val, rd);
    end
    cfg_w = w;
    cfg_h = h;
  endtask

  task automatic gen_sprite();
    stim_t spr[$];
    int ncmd;
    int r;
    int len;
    logic [OP_W-1:0] op;
    logic [ARG_W-1:0] arg;
    logic [15:0] w;
    ncmd = $urandom_range(1, 6);
    repeat (ncmd) begin
      r = $urandom_range(0, 9);
      len = 0;
      if (r < 4) begin
        op = (r < 2) ? OP_COL : OP_ROW;
        arg = ($urandom_range(0, 3) == 0) ? ARG_W'($urandom) : ARG_W'($urandom_range(0, 40));
      end else begin
        op = OP_RUN;
        r = $urandom_range(0, 99);
        len = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        arg = ARG_W'(len);
      end
      w = {arg, op};
      spr.push_back(make_beat(w[7:0], 1'b0, CHK_MODEL, KIND_PIXEL));
      spr.push_back(make_beat(w[15:8], 1'b0, CHK_MODEL, KIND_PIXEL));
      repeat (len) spr.push_back(make_beat(BYTE_W'($urandom), 1'b0, CHK_MODEL, KIND_PIXEL));
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      w = {ARG_W'($urandom), OP_END};
      spr.push_back(make_beat(w[7:0], 1'b0, CHK_MODEL, KIND_PIXEL));
      spr.push_back(make_beat(w[15:8], 1'b1, CHK_MODEL, KIND_PIXEL));
    end else if (r < 72) begin
      spr[spr.size()-1].fin = 1'b1;
    end else if (r < 80) begin
      spr.push_back(make_beat(BYTE_W'($urandom), 1'b1, CHK_MODEL, KIND_PIXEL));
    end else if (r < 90) begin
      w = {ARG_W'($urandom), OP_END};
      spr.push_back(make_beat(w[7:0], 1'b0, CHK_MODEL, KIND_PIXEL));
      spr.push_back(make_beat(w[15:8], 1'b0, CHK_MODEL, KIND_PIXEL));
      repeat ($urandom_range(0, 4))
        spr.push_back(make_beat(BYTE_W'($urandom), 1'b0, CHK_MODEL, KIND_PIXEL));
      spr.push_back(make_beat(BYTE_W'($urandom), 1'b1, CHK_MODEL, KIND_PIXEL));
    end else begin
      repeat ($urandom_range(1, 8))
        spr.push_back(make_beat(BYTE_W'($urandom), 1'($urandom), CHK_MODEL, KIND_PIXEL));
      spr[spr.size()-1].fin = 1'b1;
    end
    foreach (spr[i]) stim_q.push_back(spr[i]);
    pushed += spr.size();
  endtask

  initial begin
    int target;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) begin
        drain();
        set_dims(dir_tab[i].w, dir_tab[i].h);
      end else begin
        stim_q.push_back(make_beat(dir_tab[i].b, dir_tab[i].fin, dir_tab[i].chk,
                                   dir_tab[i].kind));
      end
    end

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: set_dims(16'hFFFF, 16'hFFFF);
        1: set_dims(16'd1, 16'd1);
        2: set_dims(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)));
        3: set_dims(16'd0, 16'd0);
        4: set_dims(DIM_W'($urandom_range(1, 65535)), DIM_W'($urandom_range(1, 65535)));
        5: set_dims(16'd0, DIM_W'($urandom_range(1, 65535)));
        6: set_dims(DIM_W'($urandom_range(1, 65535)), 16'd0);
        7: set_dims(16'hFFFF, 16'd1);
        8: set_dims(16'd1, 16'hFFFF);
        default: set_dims(DIM_W'($urandom_range(1, 300)), DIM_W'($urandom_range(1, 300)));
      endcase
      quiet = (p % 4 == 1);
      if (p == 2) hold_req++;
      target = pushed + 80;
      while (pushed < target) gen_sprite();
    end

    drain();
    if (errors == 0) $display("sprite_indexed_run_decoder_top regression: pass");
    else $display("sprite_indexed_run_decoder_top regression: fail");
    $finish;
  end

endmodule
